FILE: hdl/mfd_pkg.sv
// Shared types and constants for the multiplexed frame deframer.
// Used by mfd_varint and mplex_frame_deframer_unit; depends on nothing.
`timescale 1ns / 1ps

package mfd_pkg;

  // Varint limits: at most 63 value bits, spread over 7-bit digits.
  localparam int MAX_VARINT_BYTES_DEF = 9;
  localparam int ACC_W                = 63;
  localparam int DIGIT_W              = 7;
  localparam int VARINT_DIGITS        = 9;

  // Field widths of the frame and of the configuration registers.
  localparam int BYTE_W    = 8;
  localparam int ID_W      = 60;
  localparam int LIMIT_W   = 61;
  localparam int FLAG_W    = 3;
  localparam int LEN_W     = 32;
  localparam int KIND_W    = 2;
  localparam int ERR_W     = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 64;
  localparam int OUT_DAT_W = 112;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD_LEN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_ID_LIMIT = 8'd1;
  localparam logic [LEN_W-1:0]     MAX_LEN_RESET       = 32'd1048576;
  localparam logic [LIMIT_W-1:0]   ID_LIMIT_RESET      = 61'h1000000000000000;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_BAD_VARINT = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ID_LIMIT   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LEN_LIMIT  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd3;

  typedef enum logic [3:0] {
    PH_HDR  = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_DEAD = 4'b1000
  } phase_t;

  // Outcome of absorbing one varint byte.
  typedef struct packed {
    logic done;
    logic bad;
  } varint_status_t;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   stream_id;
    logic [FLAG_W-1:0] flag;
    logic [LEN_W-1:0]  payload_len;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
    logic [ERR_W-1:0]  error_code;
  } result_t;

endpackage

FILE: hdl/mfd_varint.sv
// Absorbs one byte of an unsigned LEB128 varint into the running value.
// Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_varint #(
  parameter int MAX_VARINT_BYTES = mfd_pkg::MAX_VARINT_BYTES_DEF,
  parameter int CNT_W            = $clog2(MAX_VARINT_BYTES + 1)
) (
  input  logic [CNT_W-1:0]          count,
  input  logic [mfd_pkg::ACC_W-1:0] accum,
  input  logic [7:0]                data_byte,
  output logic [CNT_W-1:0]          count_next,
  output logic [mfd_pkg::ACC_W-1:0] accum_next,
  output mfd_pkg::varint_status_t   status
);
  import mfd_pkg::*;

  logic [DIGIT_W-1:0] bits;
  logic               cont;
  logic               overflow;
  logic               non_minimal;
  logic               too_long;

  assign bits = data_byte[DIGIT_W-1:0];
  assign cont = data_byte[7];

  // Place the digit at position 7 * count; digits past bit 62 have no room.
  always_comb begin
    accum_next = accum;
    for (int i = 0; i < VARINT_DIGITS; i++) begin
      if (int'(count) == i) begin
        accum_next[i*DIGIT_W +: DIGIT_W] = accum[i*DIGIT_W +: DIGIT_W] | bits;
      end
    end
  end

  assign count_next  = count + CNT_W'(1);
  assign overflow    = (int'(count) >= VARINT_DIGITS) && (bits != '0);
  assign non_minimal = !cont && (count != '0) && (bits == '0);
  assign too_long    = cont && (int'(count) == MAX_VARINT_BYTES - 1);

  assign status.bad  = overflow || non_minimal || too_long;
  assign status.done = !cont && !status.bad;

endmodule

FILE: hdl/mplex_frame_deframer_unit.sv
// Top level of the multiplexed frame deframer: handshakes, frame state, result register.
// Depends on mfd_pkg and mfd_varint.
`timescale 1ns / 1ps

// Usage:
// Bytes of the multiplexed stream enter on the s_ stream channel, one beat per
// byte. Each frame is a header varint (stream id << 3 | flag), a length varint
// and that many payload bytes. The m_ channel gives one header beat after the
// length varint, then one beat per payload byte; m_tlast marks the final beat
// of a frame, which is the header beat itself when the length is zero.
// A malformed varint, a stream id at or above stream_id_limit, or a length
// above max_payload_len gives one error beat, after which every byte is
// dropped until reset. Varint bytes themselves produce no beat.
// Throughput is one byte per cycle while the receiver keeps m_tready high:
// each byte is held in the input register, is decoded against the frame
// state in a single pass and lands in the result register, from which its
// beat is offered on the m_ channel.
// When the receiver stalls, the result register holds its beat and
// the input register still takes one more byte; after that s_tready falls.
// Configuration writes on the cfg_ channel are always ready and are meant to
// be issued while the block is idle. Synchronous reset restores the register
// defaults and puts the block at the start of a frame header.

module mplex_frame_deframer_unit #(
  parameter int MAX_VARINT_BYTES = mfd_pkg::MAX_VARINT_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream. s_tdata: data_byte[7:0].
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mfd_pkg::BYTE_W-1:0]          s_tdata,
  // Result stream. m_tdata: stream_id[59:0], flag[62:60], payload_len[94:63],
  // payload_byte[102:95], error_code[104:103], zero[111:105].
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mfd_pkg::OUT_DAT_W-1:0]       m_tdata,
  // m_tuser: kind[1:0].
  output logic [mfd_pkg::KIND_W-1:0]          m_tuser,
  output logic                                m_tlast,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfd_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import mfd_pkg::*;

  localparam int CNT_W = $clog2(MAX_VARINT_BYTES + 1);

  // Configuration registers.
  logic [LEN_W-1:0]   max_payload_len;
  logic [LIMIT_W-1:0] stream_id_limit;

  // Input register.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // Frame state.
  phase_t             phase, phase_next;
  logic [ACC_W-1:0]   varint_accum, varint_accum_next;
  logic [CNT_W-1:0]   varint_bytes, varint_bytes_next;
  logic [ID_W-1:0]    frame_stream_id, frame_stream_id_next;
  logic [FLAG_W-1:0]  frame_flag, frame_flag_next;
  logic [LEN_W-1:0]   frame_length, frame_length_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;

  // Varint unit outputs.
  logic [CNT_W-1:0]   vi_count;
  logic [ACC_W-1:0]   vi_accum;
  varint_status_t     vi_status;

  // Result register.
  logic               out_valid;
  result_t            out_res;
  result_t            res;
  logic               res_valid;

  logic               advance;
  logic [LEN_W-1:0]   left_dec;

  // The byte in the input register moves on when the result slot is free or
  // being emptied in this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_LEN_RESET;
      stream_id_limit <= ID_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_PAYLOAD_LEN: max_payload_len <= cfg_data[LEN_W-1:0];
        REG_STREAM_ID_LIMIT: stream_id_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  mfd_varint #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
    .CNT_W            (CNT_W)
  ) u_varint (
    .count      (varint_bytes),
    .accum      (varint_accum),
    .data_byte  (in_byte),
    .count_next (vi_count),
    .accum_next (vi_accum),
    .status     (vi_status)
  );

  assign left_dec = bytes_left - LEN_W'(1);

  always_comb begin
    phase_next           = phase;
    varint_accum_next    = varint_accum;
    varint_bytes_next    = varint_bytes;
    frame_stream_id_next = frame_stream_id;
    frame_flag_next      = frame_flag;
    frame_length_next    = frame_length;
    bytes_left_next      = bytes_left;
    res_valid            = 1'b0;
    res                  = '0;
    res.error_code       = ERR_NONE;

    case (phase)
      PH_HDR, PH_LEN: begin
        if (vi_status.bad) begin
          phase_next     = PH_DEAD;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_BAD_VARINT;
        end else if (!vi_status.done) begin
          varint_accum_next = vi_accum;
          varint_bytes_next = vi_count;
        end else if (phase == PH_HDR) begin
          if ({1'b0, vi_accum[ACC_W-1:FLAG_W]} >= stream_id_limit) begin
            phase_next     = PH_DEAD;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_ID_LIMIT;
          end else begin
            frame_stream_id_next = vi_accum[ACC_W-1:FLAG_W];
            frame_flag_next      = vi_accum[FLAG_W-1:0];
            varint_accum_next    = '0;
            varint_bytes_next    = '0;
            phase_next           = PH_LEN;
          end
        end else begin
          if (vi_accum > {{(ACC_W-LEN_W){1'b0}}, max_payload_len}) begin
            phase_next     = PH_DEAD;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_LEN_LIMIT;
          end else begin
            frame_length_next = vi_accum[LEN_W-1:0];
            bytes_left_next   = vi_accum[LEN_W-1:0];
            varint_accum_next = '0;
            varint_bytes_next = '0;
            phase_next        = (vi_accum[LEN_W-1:0] == '0) ? PH_HDR : PH_PAY;
            res_valid         = 1'b1;
            res.kind          = KIND_HEADER;
            res.stream_id     = frame_stream_id;
            res.flag          = frame_flag;
            res.payload_len   = vi_accum[LEN_W-1:0];
            res.last          = (vi_accum[LEN_W-1:0] == '0);
          end
        end
      end
      PH_PAY: begin
        bytes_left_next  = left_dec;
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.stream_id    = frame_stream_id;
        res.flag         = frame_flag;
        res.payload_len  = frame_length;
        res.payload_byte = in_byte;
        res.last         = (left_dec == '0);
        if (left_dec == '0) begin
          phase_next = PH_HDR;
        end
      end
      default: begin
        // After an error every byte is dropped.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR;
      varint_accum <= '0;
      varint_bytes <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      varint_accum <= varint_accum_next;
      varint_bytes <= varint_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_stream_id <= frame_stream_id_next;
      frame_flag      <= frame_flag_next;
      frame_length    <= frame_length_next;
      bytes_left      <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {7'b0, out_res.error_code, out_res.payload_byte,
                     out_res.payload_len, out_res.flag, out_res.stream_id};

endmodule

FILE: tb/sv/mplex_frame_deframer_unit_tb.sv
// Self-checking testbench for mplex_frame_deframer_unit: byte beats in, header,
// payload and error beats out, checked against a behavioral deframer.
// Depends on mfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module mplex_frame_deframer_unit_tb;
  import mfd_pkg::*;

  localparam int VARINT_LIMIT = MAX_VARINT_BYTES_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BYTES = 1840;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES  = 300;

  typedef logic [BYTE_W-1:0] body_t[$];

  // Outcome of one varint byte in the behavioral deframer.
  typedef enum int {DIGIT_MORE, DIGIT_DONE, DIGIT_BAD} digit_step_t;

  // Ways to kill the block at the end of the run; only one can be used,
  // since the block stays dead until reset.
  typedef enum int {
    FATAL_OVERLONG,
    FATAL_NONMINIMAL,
    FATAL_ID_LIMIT,
    FATAL_LEN_LIMIT,
    FATAL_ZERO_LIMIT
  } fatal_case_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DAT_W-1:0]  m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_data  = '0;

  // Behavioral copy of the registers and the frame state.
  logic [LEN_W-1:0]      max_len_reg;
  logic [LIMIT_W-1:0]    id_limit_reg;
  phase_t                dp_phase;
  logic [ACC_W-1:0]      acc;
  int                    acc_bytes;
  logic [ID_W-1:0]       cur_id;
  logic [FLAG_W-1:0]     cur_flag;
  logic [LEN_W-1:0]      cur_len;
  logic [LEN_W-1:0]      left;

  // Beats predicted but not yet seen on the result channel, oldest first.
  result_t               pending_beats[$];

  int                    failures    = 0;
  int                    cycle_count = 0;
  int                    bytes_sent  = 0;
  int                    hold_req    = 0;
  int                    hold_left   = 0;
  int                    rx_gap      = 0;
  bit                    tx_quiet    = 1'b0;
  bit                    rx_quiet    = 1'b0;

  mplex_frame_deframer_unit #(
    .MAX_VARINT_BYTES(VARINT_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hard stop in case the block hangs or never delivers a beat.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mplex_frame_deframer_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Behavioral deframer
  // ---------------------------------------------------------------------------

  task automatic reset_model();
    max_len_reg  = MAX_LEN_RESET;
    id_limit_reg = ID_LIMIT_RESET;
    dp_phase     = PH_HDR;
    acc          = '0;
    acc_bytes    = 0;
    cur_id       = '0;
    cur_flag     = '0;
    cur_len      = '0;
    left         = '0;
  endtask

  // Folds one LEB128 byte into the accumulator. A digit that would carry
  // value bits past bit 62, a continuation bit on the last allowed byte, or a
  // zero final byte of a multi-byte varint all make the varint malformed.
  function automatic digit_step_t take_digit(input logic [BYTE_W-1:0] b);
    logic [63:0] bits;
    logic [63:0] placed;
    int          shift;
    bits  = {57'b0, b[6:0]};
    shift = 7 * acc_bytes;
    if (shift >= ACC_W) begin
      if (bits != 0) return DIGIT_BAD;
    end else begin
      if ((bits >> (ACC_W - shift)) != 0) return DIGIT_BAD;
      placed = bits << shift;
      acc    = acc | placed[ACC_W-1:0];
    end
    acc_bytes++;
    if (!b[7]) begin
      if (acc_bytes > 1 && bits == 0) return DIGIT_BAD;
      return DIGIT_DONE;
    end
    if (acc_bytes >= VARINT_LIMIT) return DIGIT_BAD;
    return DIGIT_MORE;
  endfunction

  // An error beat carries only its code; the block is dead afterwards.
  task automatic raise_error(input logic [ERR_W-1:0] code);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    dp_phase     = PH_DEAD;
    pending_beats.push_back(r);
  endtask

  // Advances the frame state by one accepted byte and queues the beat it causes.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    result_t     r;
    digit_step_t st;
    r            = '0;
    r.error_code = ERR_NONE;
    case (dp_phase)
      PH_HDR, PH_LEN: begin
        st = take_digit(b);
        if (st == DIGIT_BAD) begin
          raise_error(ERR_BAD_VARINT);
        end else if (st == DIGIT_DONE && dp_phase == PH_HDR) begin
          if (acc[ACC_W-1:3] >= id_limit_reg) begin
            raise_error(ERR_ID_LIMIT);
          end else begin
            cur_id    = acc[ACC_W-1:3];
            cur_flag  = acc[2:0];
            acc       = '0;
            acc_bytes = 0;
            dp_phase  = PH_LEN;
          end
        end else if (st == DIGIT_DONE) begin
          if (acc > max_len_reg) begin
            raise_error(ERR_LEN_LIMIT);
          end else begin
            cur_len       = acc[LEN_W-1:0];
            left          = cur_len;
            acc           = '0;
            acc_bytes     = 0;
            dp_phase      = (cur_len == 0) ? PH_HDR : PH_PAY;
            r.kind        = KIND_HEADER;
            r.stream_id   = cur_id;
            r.flag        = cur_flag;
            r.payload_len = cur_len;
            r.last        = (cur_len == 0);
            pending_beats.push_back(r);
          end
        end
      end
      PH_PAY: begin
        left           = left - 1;
        r.kind         = KIND_PAYLOAD;
        r.stream_id    = cur_id;
        r.flag         = cur_flag;
        r.payload_len  = cur_len;
        r.payload_byte = b;
        r.last         = (left == 0);
        pending_beats.push_back(r);
        if (left == 0) dp_phase = PH_HDR;
      end
      default: begin
        // Dead: every byte is dropped.
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_failure(input string what, input logic [63:0] want,
                                input logic [63:0] got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) report_failure({"mismatch on ", name}, want, got);
  endtask

  // m_tdata from bit 0 up: stream_id[59:0], flag[62:60], payload_len[94:63],
  // payload_byte[102:95], error_code[104:103]; kind is on m_tuser.
  always @(posedge clk) begin : beat_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        report_failure("beat with nothing expected, kind", '1, 64'(m_tuser));
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", 64'(want.kind), 64'(m_tuser));
        check_field("stream_id", 64'(want.stream_id), 64'(m_tdata[59:0]));
        check_field("flag", 64'(want.flag), 64'(m_tdata[62:60]));
        check_field("payload_len", 64'(want.payload_len), 64'(m_tdata[94:63]));
        check_field("payload_byte", 64'(want.payload_byte), 64'(m_tdata[102:95]));
        check_field("last", 64'(want.last), 64'(m_tlast));
        check_field("error_code", 64'(want.error_code), 64'(m_tdata[104:103]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver side. A hold request keeps m_tready low for a fixed count of
  // cycles so that the result and input registers both fill and s_tready drops.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_gap = rx_quiet ? 0 : pick_gap();
    end
  end

  // Offers one byte beat and waits for it to be taken. With no gap, tvalid
  // stays high so that the next call continues the burst.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
    bytes_sent++;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Minimal LEB128 encoding, low digit first.
  task automatic send_varint(input logic [ACC_W-1:0] v);
    while (v >= 128) begin
      send_byte({1'b1, v[6:0]});
      v = v >> 7;
    end
    send_byte({1'b0, v[6:0]});
  endtask

  task automatic send_frame(input logic [ID_W-1:0] id, input logic [FLAG_W-1:0] flag,
                            input body_t body);
    logic [ACC_W-1:0] n;
    n = ACC_W'(body.size());
    send_varint({id, flag});
    send_varint(n);
    foreach (body[i]) send_byte(body[i]);
  endtask

  // Varint bytes produce no beat, so the block may still hold one in its
  // input register after the queue empties; the drain lets it pass through.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_MAX_PAYLOAD_LEN) max_len_reg = value[LEN_W-1:0];
    else if (idx == REG_STREAM_ID_LIMIT) id_limit_reg = value[LIMIT_W-1:0];
  endtask

  task automatic set_config(input logic [CFG_DAT_W-1:0] len_word,
                            input logic [CFG_DAT_W-1:0] limit_word);
    wait_idle();
    write_reg(REG_MAX_PAYLOAD_LEN, len_word);
    write_reg(REG_STREAM_ID_LIMIT, limit_word);
  endtask

  // Sometimes sets the bits above a register's width; the block must drop them.
  function automatic logic [CFG_DAT_W-1:0] with_junk(input logic [CFG_DAT_W-1:0] v,
                                                     input int width);
    logic [CFG_DAT_W-1:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 2) != 0) return v;
    return v | ((junk >> width) << width);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A zero-length frame: the header beat itself is the last beat.
  task automatic test_empty_frame();
    body_t none;
    send_frame('0, '0, none);
  endtask

  // Largest id and flag give a nine-byte header varint with all 63 bits set.
  task automatic test_widest_header();
    body_t body;
    body.push_back(8'hFF);
    send_frame('1, 3'd7, body);
  endtask

  task automatic test_payload_extremes();
    body_t body;
    body.push_back(8'h00);
    body.push_back(8'h80);
    send_frame(60'd1, 3'd5, body);
  endtask

  // Tightest limits first, then a length exactly at the maximum, then the
  // widest settings for what follows.
  task automatic test_register_extremes();
    body_t none;
    body_t body;
    set_config(64'd0, 64'd1);
    send_frame('0, 3'd3, none);
    set_config(64'd3, 64'd2);
    repeat (3) body.push_back(BYTE_W'($urandom));
    send_frame(60'd1, 3'd6, body);
    set_config(64'hFFFF_FFFF, {3'b0, ID_LIMIT_RESET});
  endtask

  // The receiver stops for a long stretch while bytes keep coming back to back.
  task automatic test_back_pressure();
    body_t body;
    repeat (48) body.push_back(BYTE_W'($urandom));
    tx_quiet = 1'b1;
    hold_req = HOLD_CYCLES;
    send_frame(60'd9, 3'd2, body);
    tx_quiet = 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_DAT_W-1:0] len_word;
    logic [CFG_DAT_W-1:0] limit_word;
    case ($urandom_range(0, 4))
      0: len_word = 64'd0;
      1: len_word = 64'd1;
      2: len_word = CFG_DAT_W'($urandom_range(2, 64));
      3: len_word = 64'hFFFF_FFFF;
      default: len_word = CFG_DAT_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: limit_word = 64'd1;
      1: limit_word = CFG_DAT_W'($urandom_range(2, 16));
      2: limit_word = {3'b0, ID_LIMIT_RESET};
      3: limit_word = {$urandom, $urandom} & {3'b0, {LIMIT_W{1'b1}}};
      default: limit_word = {$urandom, $urandom} >> $urandom_range(3, 60);
    endcase
    if (limit_word == 0) limit_word = 64'd1;
    set_config(with_junk(len_word, LEN_W), with_junk(limit_word, LIMIT_W));
  endtask

  // A well-formed frame with an id of random width kept under the limit and
  // a length kept within the maximum; a few lengths need a two-byte varint.
  task automatic send_random_frame();
    logic [63:0]     raw;
    logic [ID_W-1:0] id;
    body_t           body;
    int              roll;
    int              n;
    raw = {$urandom, $urandom};
    raw = raw >> $urandom_range(4, 64);
    id  = raw[ID_W-1:0];
    if (id >= id_limit_reg) id = ID_W'(id % id_limit_reg);
    roll = $urandom_range(0, 99);
    if (roll < 3) n = $urandom_range(128, 200);
    else if (roll < 15) n = $urandom_range(0, 40);
    else n = $urandom_range(0, 8);
    if (n > max_len_reg) n = max_len_reg;
    repeat (n) body.push_back(BYTE_W'($urandom));
    send_frame(id, FLAG_W'($urandom), body);
  endtask

  task automatic test_random_frames();
    int goal;
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      random_config();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      for (int k = $urandom_range(6, 20); k > 0 && bytes_sent < goal; k--)
        send_random_frame();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // One malformed frame, picked at random, then bytes that must be dropped.
  task automatic test_fatal_error();
    fatal_case_t       pick;
    logic [FLAG_W-1:0] flag;
    logic [ID_W-1:0]   id;
    logic [ACC_W-1:0]  len;
    int                lim;
    flag = FLAG_W'($urandom);
    pick = fatal_case_t'($urandom_range(0, 4));
    case (pick)
      FATAL_OVERLONG: begin
        // Optionally break the length varint instead of the header.
        if ($urandom_range(0, 1) != 0) send_varint({60'd0, flag});
        repeat (VARINT_LIMIT) send_byte({1'b1, 7'($urandom)});
      end
      FATAL_NONMINIMAL: begin
        if ($urandom_range(0, 1) != 0) send_varint({60'd0, flag});
        send_byte({1'b1, 7'($urandom)});
        repeat ($urandom_range(0, VARINT_LIMIT - 2)) send_byte({1'b1, 7'($urandom)});
        send_byte(8'h00);
      end
      FATAL_ID_LIMIT: begin
        lim = $urandom_range(1, 1000);
        set_config(64'(max_len_reg), 64'(lim));
        id = ID_W'(lim) + ID_W'($urandom_range(0, 50));
        send_varint({id, flag});
      end
      FATAL_LEN_LIMIT: begin
        lim = $urandom_range(0, 100);
        set_config(64'(lim), {3'b0, ID_LIMIT_RESET});
        send_varint({60'd5, flag});
        len = ACC_W'(lim) + ACC_W'(1) + ACC_W'($urandom_range(0, 1000));
        send_varint(len);
      end
      default: begin
        // A zero limit rejects even stream id 0.
        set_config(64'(max_len_reg), with_junk(64'd0, LIMIT_W));
        send_varint({60'd0, flag});
      end
    endcase
    repeat (24) send_byte(BYTE_W'($urandom));
  endtask

  initial begin : run
    int waited;
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_frame();
    test_widest_header();
    test_payload_extremes();
    test_register_extremes();
    test_back_pressure();
    test_random_frames();
    test_fatal_error();

    s_tvalid <= 1'b0;
    for (waited = 0; waited < 2000 && pending_beats.size() != 0; waited++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0)
      report_failure("expected beats never delivered, count",
                     64'(pending_beats.size()), 64'd0);

    if (failures == 0) begin
      $display("mplex_frame_deframer_unit verification clean");
    end else begin
      $display("mplex_frame_deframer_unit verification failed");
    end
    $finish;
  end

endmodule
